// ===== rtl/sst_pkg.sv =====
// shared types and codes of the sparse set slot table
package sst_pkg;

   localparam int ID_FIELD_W   = 10;
   localparam int SLOT_FIELD_W = 10;
   localparam int LIVE_FIELD_W = 10;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = 1;
   localparam int QCNT_W       = 2;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_PRESENT  = 3'd1;
   localparam logic [2:0] ST_REMOVED  = 3'd2;
   localparam logic [2:0] ST_ABSENT   = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_RESET    = 3'd5;

   typedef struct packed {
      logic [1:0]            action;
      logic [ID_FIELD_W-1:0] element_id;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [SLOT_FIELD_W-1:0] slot_index;
      logic [LIVE_FIELD_W-1:0] live_total;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_INSERT_BAD,
      OP_REMOVE,
      OP_REMOVE_BAD,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [ID_FIELD_W-1:0] element_id;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

// ===== rtl/sparse_set_slot_table.sv =====
// top level of the sparse set slot table
// Membership table for element ids with slot reuse. Requests enter through a
// two-entry command queue and results leave through a two-entry result queue,
// so up to two requests may be waiting while earlier results are not yet
// popped. In the execution unit an insert or remove reads the id map memory
// and the free slot stack memory in the idle state and updates them in the
// exec state. An id outside the id space is answered from the idle state.
// A table reset request sweeps the presence bits of the id map, one entry a
// cycle. The same sweep runs after reset; req_full stays high while it runs.
module sparse_set_slot_table import sst_pkg::*; #(
   parameter int ID_SPACE   = 1024,
   parameter int SLOT_COUNT = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cmd_type cmd_data;
   logic    cmd_empty, cmd_pop;
   logic    res_full, res_push;
   rsp_type res_data;
   logic    clearing;

   sst_front #(.ID_SPACE(ID_SPACE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .hold      (clearing),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty)
   );

   sst_back #(.ID_SPACE(ID_SPACE), .SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_data  (res_data),
      .clearing  (clearing)
   );

   sst_fifo #(.T(rsp_type)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_data),
      .full    (res_full),
      .pop     (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

`ifndef SYNTH
   // a result must never be dropped at the result queue
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full queue");

   a_cmd_avail: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty queue");

   // an insert or remove taken on one cycle gives no second command on the next
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && (cmd_data.op == OP_INSERT || cmd_data.op == OP_REMOVE) |=> !cmd_pop)
      else $error("execution unit took two commands back to back");

   a_no_intake_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("request taken during presence sweep");
`endif

endmodule

// ===== rtl/sst_ram.sv =====
// generic single write port ram with registered read
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sst_fifo.sv =====
// small register queue of fixed depth
module sst_fifo import sst_pkg::*; #(
   parameter type T = logic
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     wr_data,
   output logic full,
   input  logic pop,
   output T     rd_data,
   output logic empty
);

   T                    entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/sst_front.sv =====
// request intake: range check, classification and command queue
module sst_front import sst_pkg::*; #(
   parameter int ID_SPACE = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    cmd_pop,
   output cmd_type cmd_data,
   output logic    cmd_empty
);

   cmd_type cmd_new;
   logic    in_range;
   logic    q_full;

   assign in_range = (17'(req_data.element_id) < 17'(ID_SPACE));

   always_comb begin
      cmd_new.element_id = req_data.element_id;
      case (req_data.action)
         ACT_INSERT: cmd_new.op = in_range ? OP_INSERT : OP_INSERT_BAD;
         ACT_REMOVE: cmd_new.op = in_range ? OP_REMOVE : OP_REMOVE_BAD;
         default:    cmd_new.op = OP_CLEAR;
      endcase
   end

   // no intake while the presence bits are being swept
   assign req_full = q_full || hold;

   sst_fifo #(.T(cmd_type)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push && !hold),
      .wr_data (cmd_new),
      .full    (q_full),
      .pop     (cmd_pop),
      .rd_data (cmd_data),
      .empty   (cmd_empty)
   );

endmodule

// ===== rtl/sst_back.sv =====
// command execution: id map, free slot stack and counters
module sst_back import sst_pkg::*; #(
   parameter int ID_SPACE   = 1024,
   parameter int SLOT_COUNT = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   input  logic    res_full,
   output logic    res_push,
   output rsp_type res_data,
   output logic    clearing
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int ID_W   = $clog2(ID_SPACE);
   localparam int CNT_W  = SLOT_W + 1;
   localparam int MAP_W  = SLOT_W + 1;
   localparam int IDX_W  = (ID_W > ID_FIELD_W) ? ID_W : ID_FIELD_W;
   localparam int SX_W   = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
   localparam int LX_W   = (SLOT_W > LIVE_FIELD_W) ? SLOT_W : LIVE_FIELD_W;

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  depth_ff, depth_in;
   logic [CNT_W-1:0]  fresh_ff, fresh_in;
   logic [SLOT_W-1:0] live_ff, live_in;
   logic [ID_W-1:0]   clr_addr_ff, clr_addr_in;
   logic              report_ff, report_in;

   logic              map_we;
   logic [ID_W-1:0]   map_waddr, map_raddr;
   logic [MAP_W-1:0]  map_wdata, map_rdata;
   logic              stk_we;
   logic [SLOT_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

   logic [IDX_W-1:0]  new_id_wide, cur_id_wide;
   logic              map_pres;
   logic [SLOT_W-1:0] map_slot;
   logic [2:0]        res_status;
   logic [SLOT_W-1:0] res_slot;
   logic [SX_W-1:0]   res_slot_wide;
   logic [LX_W-1:0]   res_live_wide;

   assign new_id_wide = IDX_W'(cmd_data.element_id);
   assign cur_id_wide = IDX_W'(cmd_ff.element_id);
   assign map_raddr   = new_id_wide[ID_W-1:0];
   assign stk_raddr   = SLOT_W'(depth_ff - 1'b1);
   assign map_pres    = map_rdata[SLOT_W];
   assign map_slot    = map_rdata[SLOT_W-1:0];
   assign clearing    = (state_ff == BK_CLEAR);

   assign res_slot_wide       = SX_W'(res_slot);
   assign res_live_wide       = LX_W'(live_in);
   assign res_data.status     = res_status;
   assign res_data.slot_index = res_slot_wide[SLOT_FIELD_W-1:0];
   assign res_data.live_total = res_live_wide[LIVE_FIELD_W-1:0];

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      depth_in    = depth_ff;
      fresh_in    = fresh_ff;
      live_in     = live_ff;
      clr_addr_in = clr_addr_ff;
      report_in   = report_ff;
      cmd_pop     = 1'b0;
      res_push    = 1'b0;
      res_status  = ST_RESET;
      res_slot    = '0;
      map_we      = 1'b0;
      map_waddr   = cur_id_wide[ID_W-1:0];
      map_wdata   = '0;
      stk_we      = 1'b0;
      stk_waddr   = depth_ff[SLOT_W-1:0];
      stk_wdata   = map_slot;
      case (state_ff)
         BK_CLEAR: begin
            map_we      = 1'b1;
            map_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ID_W'(ID_SPACE - 1)) begin
               state_in   = BK_IDLE;
               res_push   = report_ff;
               res_status = ST_RESET;
            end
         end
         BK_IDLE: begin
            // result queue has room and only this unit fills it
            if (!cmd_empty && !res_full) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               case (cmd_data.op)
                  OP_INSERT_BAD: begin
                     res_push   = 1'b1;
                     res_status = ST_FULL;
                  end
                  OP_REMOVE_BAD: begin
                     res_push   = 1'b1;
                     res_status = ST_ABSENT;
                  end
                  OP_CLEAR: begin
                     state_in    = BK_CLEAR;
                     clr_addr_in = '0;
                     report_in   = 1'b1;
                     depth_in    = '0;
                     fresh_in    = CNT_W'(1);
                     live_in     = '0;
                  end
                  default: begin
                     state_in = BK_EXEC;
                  end
               endcase
            end
         end
         BK_EXEC: begin
            state_in = BK_IDLE;
            res_push = 1'b1;
            if (cmd_ff.op == OP_INSERT) begin
               if (map_pres) begin
                  res_status = ST_PRESENT;
                  res_slot   = map_slot;
               end else if (depth_ff != '0) begin
                  res_status = ST_INSERTED;
                  res_slot   = stk_rdata;
                  depth_in   = depth_ff - 1'b1;
                  live_in    = live_ff + 1'b1;
                  map_we     = 1'b1;
                  map_wdata  = {1'b1, stk_rdata};
               end else if (fresh_ff < CNT_W'(SLOT_COUNT)) begin
                  res_status = ST_INSERTED;
                  res_slot   = fresh_ff[SLOT_W-1:0];
                  fresh_in   = fresh_ff + 1'b1;
                  live_in    = live_ff + 1'b1;
                  map_we     = 1'b1;
                  map_wdata  = {1'b1, fresh_ff[SLOT_W-1:0]};
               end else begin
                  res_status = ST_FULL;
               end
            end else begin
               if (!map_pres) begin
                  res_status = ST_ABSENT;
               end else begin
                  res_status = ST_REMOVED;
                  res_slot   = map_slot;
                  map_we     = 1'b1;
                  map_wdata  = {1'b0, map_slot};
                  if (depth_ff < CNT_W'(SLOT_COUNT)) begin
                     stk_we   = 1'b1;
                     depth_in = depth_ff + 1'b1;
                  end
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         depth_ff    <= '0;
         fresh_ff    <= CNT_W'(1);
         live_ff     <= '0;
         clr_addr_ff <= '0;
         report_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         depth_ff    <= depth_in;
         fresh_ff    <= fresh_in;
         live_ff     <= live_in;
         clr_addr_ff <= clr_addr_in;
         report_ff   <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   sst_ram #(.WIDTH(MAP_W), .DEPTH(ID_SPACE)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   sst_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

endmodule
